[hw/rtl/chkv_pkg.sv]
package chkv_pkg;

	localparam int unsigned KEY_W          = 32;
	localparam int unsigned VAL_W          = 32;
	localparam int unsigned CNT_W          = 9;
	localparam int unsigned MAX_BUCKETS_D  = 256;
	localparam int unsigned POOL_ENTRIES_D = 256;
	localparam logic [CNT_W-1:0] BUCKETS_RST = CNT_W'(251);
	localparam int unsigned MOD_BITS  = 4;
	localparam int unsigned MOD_STEPS = KEY_W / MOD_BITS;

	typedef enum logic [1:0] {
		CMD_ENTER  = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value_in;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [VAL_W-1:0]  value_out;
		logic              full_res;
	} rsp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

[hw/rtl/chkv_ram.sv]
module chkv_ram #(
	parameter int unsigned W = 32,
	parameter int unsigned D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/chkv_front.sv]
module chkv_front #(
	parameter int unsigned MAX_BUCKETS = chkv_pkg::MAX_BUCKETS_D,
	parameter int unsigned BW = $clog2(MAX_BUCKETS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  chkv_pkg::req_t             req,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [chkv_pkg::CNT_W-1:0] cfg_data,
	input  chkv_pkg::qstat_t           qstat,
	output logic                       push,
	output chkv_pkg::req_t             push_item,
	output logic [BW-1:0]              push_bucket
);

	localparam int unsigned NB = $clog2(MAX_BUCKETS + 1);
	localparam int unsigned MW = $clog2(chkv_pkg::MOD_STEPS);

	logic [chkv_pkg::CNT_W-1:0] bcount_q;
	chkv_pkg::req_t             hold_q;
	logic                       hv_q;
	logic                       mdone_q;
	logic [MW-1:0]              mcnt_q;
	logic [chkv_pkg::KEY_W-1:0] ksh_q;
	logic [NB-1:0]              rem_q;
	logic [NB-1:0]              n_eff;
	logic [NB-1:0]              rem_nx;
	logic [NB:0]                r;

	assign cfg_ready = 1'b1;
	assign req_ready = !hv_q;

	always_comb begin
		if (bcount_q == '0) begin
			n_eff = NB'(1);
		end else if (32'(bcount_q) > MAX_BUCKETS) begin
			n_eff = NB'(MAX_BUCKETS);
		end else begin
			n_eff = NB'(bcount_q);
		end
	end

	always_comb begin
		rem_nx = rem_q;
		r = '0;
		for (int i = 0; i < chkv_pkg::MOD_BITS; i++) begin
			r = {rem_nx, ksh_q[chkv_pkg::KEY_W-1-i]};
			if (r >= {1'b0, n_eff}) begin
				r = r - {1'b0, n_eff};
			end
			rem_nx = r[NB-1:0];
		end
	end

	assign push        = hv_q && mdone_q && !qstat.full;
	assign push_item   = hold_q;
	assign push_bucket = BW'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= chkv_pkg::BUCKETS_RST;
			hv_q     <= 1'b0;
			mdone_q  <= 1'b0;
			mcnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				bcount_q <= cfg_data;
			end
			if (req_valid && req_ready) begin
				hv_q    <= 1'b1;
				mdone_q <= (req.command == chkv_pkg::CMD_CLEAR);
				mcnt_q  <= '0;
			end else if (hv_q && !mdone_q) begin
				mcnt_q <= mcnt_q + MW'(1);
				if (mcnt_q == MW'(chkv_pkg::MOD_STEPS - 1)) begin
					mdone_q <= 1'b1;
				end
			end else if (push) begin
				hv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			hold_q <= req;
			ksh_q  <= req.key;
			rem_q  <= '0;
		end else if (hv_q && !mdone_q) begin
			ksh_q <= ksh_q << chkv_pkg::MOD_BITS;
			rem_q <= rem_nx;
		end
	end

endmodule

[hw/rtl/chkv_fifo.sv]
module chkv_fifo #(
	parameter int unsigned W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     wdata,
	input  logic             pop,
	output logic [W-1:0]     rdata,
	output chkv_pkg::qstat_t qstat
);

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign rdata       = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

[hw/rtl/chkv_back.sv]
module chkv_back #(
	parameter int unsigned MAX_BUCKETS  = chkv_pkg::MAX_BUCKETS_D,
	parameter int unsigned POOL_ENTRIES = chkv_pkg::POOL_ENTRIES_D,
	parameter int unsigned BW = $clog2(MAX_BUCKETS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  chkv_pkg::req_t   job_item,
	input  logic [BW-1:0]    job_bucket,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output chkv_pkg::rsp_t   rsp
);

	localparam int unsigned PW   = $clog2(POOL_ENTRIES);
	localparam int unsigned LW   = PW + 1;
	localparam int unsigned MAXD = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
	localparam int unsigned SW   = $clog2(MAXD);
	localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_HEAD = 5'b00010,
		ST_WALK = 5'b00100,
		ST_EXEC = 5'b01000,
		ST_CLR  = 5'b10000
	} state_t;

	state_t                     state_q;
	chkv_pkg::cmd_t             cmd_q;
	logic [chkv_pkg::KEY_W-1:0] key_q;
	logic [chkv_pkg::VAL_W-1:0] val_q;
	logic [BW-1:0]              bkt_q;
	logic [LW-1:0]              head_q;
	logic [PW-1:0]              cur_q;
	logic [LW-1:0]              before_q;
	logic [PW-1:0]              steps_q;
	logic                       found_q;
	logic [LW-1:0]              link_q;
	logic [chkv_pkg::VAL_W-1:0] fval_q;
	logic [PW:0]                count_q;
	logic [SW-1:0]              clr_i_q;
	logic                       clr_rsp_q;
	logic                       res_valid_q;
	chkv_pkg::rsp_t             res_q;

	logic          h_we;
	logic [BW-1:0] h_waddr, h_raddr;
	logic [LW-1:0] h_wdata, h_rdata;
	logic          k_we, v_we, l_we, p_we;
	logic [PW-1:0] k_waddr, v_waddr, l_waddr, p_waddr, e_raddr, p_raddr;
	logic [chkv_pkg::KEY_W-1:0] k_rdata;
	logic [chkv_pkg::VAL_W-1:0] v_wdata, v_rdata;
	logic [LW-1:0] l_wdata, l_rdata;
	logic [PW-1:0] p_wdata, p_rdata;
	logic          k_match;
	logic          pool_has;

	chkv_ram #(.W(LW), .D(MAX_BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
	);
	chkv_ram #(.W(chkv_pkg::KEY_W), .D(POOL_ENTRIES)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(key_q), .raddr(e_raddr), .rdata(k_rdata)
	);
	chkv_ram #(.W(chkv_pkg::VAL_W), .D(POOL_ENTRIES)) u_values (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(e_raddr), .rdata(v_rdata)
	);
	chkv_ram #(.W(LW), .D(POOL_ENTRIES)) u_links (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(e_raddr), .rdata(l_rdata)
	);
	chkv_ram #(.W(PW), .D(POOL_ENTRIES)) u_pool (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
	);

	assign job_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign k_match   = (k_rdata == key_q);
	assign pool_has  = (count_q != '0);
	assign p_raddr   = PW'(count_q - (PW+1)'(1));
	assign rsp_valid = res_valid_q;
	assign rsp       = res_q;

	always_comb begin
		h_we = 1'b0; h_waddr = bkt_q; h_wdata = NIL; h_raddr = job_bucket;
		k_we = 1'b0; k_waddr = PW'(p_rdata);
		v_we = 1'b0; v_waddr = cur_q; v_wdata = val_q;
		l_we = 1'b0; l_waddr = p_rdata; l_wdata = head_q;
		p_we = 1'b0; p_waddr = PW'(count_q); p_wdata = cur_q;
		e_raddr = cur_q;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_HEAD: begin
				e_raddr = h_rdata[PW-1:0];
			end
			ST_WALK: begin
				e_raddr = l_rdata[PW-1:0];
			end
			ST_EXEC: begin
				unique case (cmd_q)
					chkv_pkg::CMD_ENTER: begin
						if (found_q) begin
							v_we = 1'b1;
						end else if (pool_has) begin
							k_we    = 1'b1;
							v_we    = 1'b1;
							v_waddr = p_rdata;
							l_we    = 1'b1;
							h_we    = 1'b1;
							h_wdata = LW'(p_rdata);
						end
					end
					chkv_pkg::CMD_REMOVE: begin
						if (found_q) begin
							if (before_q < NIL) begin
								l_we    = 1'b1;
								l_waddr = before_q[PW-1:0];
								l_wdata = link_q;
							end else begin
								h_we    = 1'b1;
								h_wdata = link_q;
							end
							p_we = (32'(count_q) < POOL_ENTRIES);
						end
					end
					default: begin
					end
				endcase
			end
			ST_CLR: begin
				h_we    = ({1'b0, clr_i_q} < (SW+1)'(MAX_BUCKETS));
				h_waddr = BW'(clr_i_q);
				p_we    = ({1'b0, clr_i_q} < (SW+1)'(POOL_ENTRIES));
				p_waddr = PW'(clr_i_q);
				p_wdata = PW'(clr_i_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_i_q     <= '0;
			clr_rsp_q   <= 1'b0;
			res_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (res_valid_q && rsp_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						if (job_item.command == chkv_pkg::CMD_CLEAR) begin
							state_q   <= ST_CLR;
							clr_i_q   <= '0;
							clr_rsp_q <= 1'b1;
						end else begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					if (h_rdata >= NIL) begin
						state_q <= ST_EXEC;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (k_match || steps_q == PW'(POOL_ENTRIES - 1) || l_rdata >= NIL) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b1;
					if (cmd_q == chkv_pkg::CMD_ENTER && !found_q && pool_has) begin
						count_q <= count_q - (PW+1)'(1);
					end else if (cmd_q == chkv_pkg::CMD_REMOVE && found_q &&
					             32'(count_q) < POOL_ENTRIES) begin
						count_q <= count_q + (PW+1)'(1);
					end
				end
				ST_CLR: begin
					clr_i_q <= clr_i_q + SW'(1);
					if (clr_i_q == SW'(MAXD - 1)) begin
						state_q     <= ST_IDLE;
						count_q     <= (PW+1)'(POOL_ENTRIES);
						res_valid_q <= clr_rsp_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid && job_ready) begin
					cmd_q <= job_item.command;
					key_q <= job_item.key;
					val_q <= job_item.value_in;
					bkt_q <= job_bucket;
					res_q <= '0;
				end
			end
			ST_HEAD: begin
				head_q   <= h_rdata;
				cur_q    <= h_rdata[PW-1:0];
				before_q <= NIL;
				steps_q  <= '0;
				found_q  <= 1'b0;
			end
			ST_WALK: begin
				if (k_match) begin
					found_q <= 1'b1;
					link_q  <= l_rdata;
					fval_q  <= v_rdata;
				end else begin
					before_q <= LW'(cur_q);
					cur_q    <= l_rdata[PW-1:0];
					steps_q  <= steps_q + PW'(1);
				end
			end
			ST_EXEC: begin
				unique case (cmd_q)
					chkv_pkg::CMD_ENTER: begin
						res_q.hit      <= !found_q && pool_has;
						res_q.full_res <= !found_q && !pool_has;
					end
					chkv_pkg::CMD_FIND: begin
						res_q.hit       <= found_q;
						res_q.value_out <= found_q ? fval_q : '0;
					end
					chkv_pkg::CMD_REMOVE: begin
						res_q.hit <= found_q;
					end
					default: begin
					end
				endcase
			end
			ST_CLR: begin
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/chained_hash_key_value_table.sv]
// A request passes the bucket modulo in the front part (4 key bits a cycle; clear skips it)
// and the queue, then the back part reads the bucket head and compares chain entries in turn.
// The front part works on the next item while the back part walks a chain.
// Clear sweeps max(MAX_BUCKETS, POOL_ENTRIES) addresses of the heads and free pool.
// Reset is asynchronous; after it the same sweep runs before the back part takes a beat.
module chained_hash_key_value_table #(
	parameter int unsigned MAX_BUCKETS  = chkv_pkg::MAX_BUCKETS_D,
	parameter int unsigned POOL_ENTRIES = chkv_pkg::POOL_ENTRIES_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  chkv_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output chkv_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [chkv_pkg::CNT_W-1:0] cfg_data
);

	localparam int unsigned BW = $clog2(MAX_BUCKETS);
	localparam int unsigned JW = $bits(chkv_pkg::req_t) + BW;

	chkv_pkg::qstat_t qstat;
	logic             push;
	chkv_pkg::req_t   push_item;
	logic [BW-1:0]    push_bucket;
	logic             pop;
	logic             job_rdy;
	logic [JW-1:0]    job;
	chkv_pkg::req_t   job_item;
	logic [BW-1:0]    job_bucket;

	chkv_front #(.MAX_BUCKETS(MAX_BUCKETS), .BW(BW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.qstat(qstat), .push(push), .push_item(push_item), .push_bucket(push_bucket)
	);

	chkv_fifo #(.W(JW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata({push_item, push_bucket}),
		.pop(pop), .rdata(job), .qstat(qstat)
	);

	assign job_item   = job[JW-1:BW];
	assign job_bucket = job[BW-1:0];
	assign pop        = job_rdy && !qstat.empty;

	chkv_back #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .BW(BW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(!qstat.empty), .job_ready(job_rdy),
		.job_item(job_item), .job_bucket(job_bucket),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

endmodule

[test/tb_chained_hash_key_value_table.sv]
module tb_chained_hash_key_value_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL = 256;
	localparam int NBKT = 256;
	localparam int NIL = 256;
	localparam longint CYCLE_LIMIT = 20_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	chkv_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	chkv_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [chkv_pkg::CNT_W-1:0] cfg_data = '0;

	chained_hash_key_value_table dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	logic [chkv_pkg::CNT_W-1:0] buckets;
	int heads[NBKT];
	logic [31:0] keys[POOL];
	logic [31:0] vals[POOL];
	int links[POOL];
	int pool[POOL];
	int nfree;

	chkv_pkg::rsp_t pending[$];
	int errors = 0;
	longint cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int lo_keys = 0;

	typedef struct {
		chkv_pkg::req_t r;
		bit known;
		chkv_pkg::rsp_t want;
	} row_t;

	function automatic void table_empty();
		for (int i = 0; i < NBKT; i++) heads[i] = NIL;
		for (int i = 0; i < POOL; i++) pool[i] = i;
		nfree = POOL;
	endfunction

	function automatic chkv_pkg::rsp_t table_apply(chkv_pkg::req_t r);
		chkv_pkg::rsp_t o;
		int n, b, cur, prv, slot;
		o = '0;
		if (r.command == chkv_pkg::CMD_CLEAR) begin
			table_empty();
			return o;
		end
		n = buckets;
		if (n == 0) n = 1;
		if (n > NBKT) n = NBKT;
		b = r.key % n;
		cur = heads[b];
		prv = NIL;
		slot = NIL;
		for (int s = 0; s < POOL; s++) begin
			if (cur >= POOL) break;
			if (keys[cur] == r.key) begin
				slot = cur;
				break;
			end
			prv = cur;
			cur = links[cur];
		end
		if (slot == NIL) prv = NIL;
		case (r.command)
			chkv_pkg::CMD_ENTER: begin
				if (slot != NIL) vals[slot] = r.value_in;
				else if (nfree == 0) o.full_res = 1'b1;
				else begin
					nfree--;
					slot = pool[nfree];
					keys[slot] = r.key;
					vals[slot] = r.value_in;
					links[slot] = heads[b];
					heads[b] = slot;
					o.hit = 1'b1;
				end
			end
			chkv_pkg::CMD_FIND: begin
				if (slot != NIL) begin
					o.hit = 1'b1;
					o.value_out = vals[slot];
				end
			end
			default: begin
				if (slot != NIL) begin
					if (prv < POOL) links[prv] = links[slot];
					else heads[b] = links[slot];
					if (nfree < POOL) begin
						pool[nfree] = slot;
						nfree++;
					end
					o.hit = 1'b1;
				end
			end
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_chained_hash_key_value_table: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		chkv_pkg::rsp_t w;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected beat %h", $time, rsp);
				errors++;
			end else begin
				w = pending.pop_front();
				if (w.hit !== rsp.hit) begin
					$display("%0t hit exp %b got %b", $time, w.hit, rsp.hit);
					errors++;
				end
				if (w.value_out !== rsp.value_out) begin
					$display("%0t value exp %h got %h", $time, w.value_out, rsp.value_out);
					errors++;
				end
				if (w.full_res !== rsp.full_res) begin
					$display("%0t full exp %b got %b", $time, w.full_res, rsp.full_res);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (recv_stall > 0 && $urandom_range(99) < recv_stall) rsp_ready <= 1'b0;
		else rsp_ready <= 1'b1;
	end

	task automatic send(chkv_pkg::req_t r, bit known, chkv_pkg::rsp_t want);
		chkv_pkg::rsp_t p;
		@(negedge clk);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		p = table_apply(r);
		if (known && p !== want) begin
			$display("%0t table row exp %h model %h", $time, want, p);
			errors++;
		end
		pending.push_back(p);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_buckets(logic [chkv_pkg::CNT_W-1:0] n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		buckets = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic chkv_pkg::req_t mk(chkv_pkg::cmd_t c, logic [31:0] k, logic [31:0] v);
		chkv_pkg::req_t r;
		r.command = c;
		r.key = k;
		r.value_in = v;
		return r;
	endfunction

	function automatic chkv_pkg::rsp_t rs(bit h, logic [31:0] v, bit f);
		chkv_pkg::rsp_t o;
		o.hit = h;
		o.value_out = v;
		o.full_res = f;
		return o;
	endfunction

	function automatic logic [31:0] pick_key();
		if (lo_keys > 0) return 32'($urandom_range(lo_keys - 1));
		return $urandom;
	endfunction

	task automatic random_run(int count, int span);
		int c;
		lo_keys = span;
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(99);
			if (c < 45) send(mk(chkv_pkg::CMD_ENTER, pick_key(), $urandom), 0, '0);
			else if (c < 75) send(mk(chkv_pkg::CMD_FIND, pick_key(), $urandom), 0, '0);
			else if (c < 99) send(mk(chkv_pkg::CMD_REMOVE, pick_key(), $urandom), 0, '0);
			else send(mk(chkv_pkg::CMD_CLEAR, $urandom, $urandom), 0, '0);
		end
	endtask

	row_t rows[$];

	initial begin
		buckets = chkv_pkg::BUCKETS_RST;
		table_empty();
		for (int i = 0; i < POOL; i++) begin
			keys[i] = '0;
			vals[i] = '0;
			links[i] = 0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		rows.push_back('{mk(chkv_pkg::CMD_FIND, 32'h0, 32'h0), 1, rs(0, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0), 1, rs(0, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
			rs(1, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'h0), 1,
			rs(1, 32'hFFFF_FFFF, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_ENTER, 32'h0, 32'h0), 1, rs(1, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_ENTER, 32'd251, 32'h5A5A_A5A5), 1, rs(1, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_ENTER, 32'd502, 32'h1), 0, '0});
		rows.push_back('{mk(chkv_pkg::CMD_ENTER, 32'd251, 32'h1234_5678), 1, rs(0, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_FIND, 32'd251, 32'h0), 0, '0});
		rows.push_back('{mk(chkv_pkg::CMD_REMOVE, 32'd251, 32'h0), 1, rs(1, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_FIND, 32'd502, 32'h0), 0, '0});
		rows.push_back('{mk(chkv_pkg::CMD_REMOVE, 32'd502, 32'h0), 0, '0});
		rows.push_back('{mk(chkv_pkg::CMD_FIND, 32'h0, 32'h0), 0, '0});
		rows.push_back('{mk(chkv_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
			rs(0, 0, 0)});
		rows.push_back('{mk(chkv_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'h0), 1, rs(0, 0, 0)});
		foreach (rows[i]) send(rows[i].r, rows[i].known, rows[i].want);

		// pool exhaustion, then overwrite while full
		write_buckets(9'd1);
		for (int i = 0; i < POOL; i++) send(mk(chkv_pkg::CMD_ENTER, 32'(i * 7), 32'(i)), 0, '0);
		send(mk(chkv_pkg::CMD_ENTER, 32'hDEAD_BEEF, 32'h0), 1, rs(0, 0, 1));
		send(mk(chkv_pkg::CMD_ENTER, 32'd7, 32'hCAFE_F00D), 1, rs(0, 0, 0));
		send(mk(chkv_pkg::CMD_FIND, 32'd7, 32'h0), 1, rs(1, 32'hCAFE_F00D, 0));
		send(mk(chkv_pkg::CMD_REMOVE, 32'd0, 32'h0), 1, rs(1, 0, 0));
		send(mk(chkv_pkg::CMD_ENTER, 32'hDEAD_BEEF, 32'h0), 1, rs(1, 0, 0));
		send(mk(chkv_pkg::CMD_CLEAR, 32'h0, 32'h0), 1, rs(0, 0, 0));

		write_buckets(9'd0);
		random_run(80, 40);
		write_buckets(9'd256);
		random_run(80, 600);
		write_buckets(9'd511);
		random_run(60, 600);
		// divisor change with live entries
		write_buckets(9'd5);
		random_run(60, 30);

		send_idle = 65;
		write_buckets(9'd3);
		random_run(250, 64);
		send_idle = 0;
		recv_stall = 65;
		write_buckets(9'd17);
		random_run(250, 400);
		send_idle = 7;
		recv_stall = 7;
		write_buckets(9'($urandom_range(1, 256)));
		random_run(300, 512);
		drain();
		send_idle = 0;
		recv_stall = 0;
		write_buckets(chkv_pkg::BUCKETS_RST);
		random_run(100, 0);
		random_run(250, 2048);

		drain();
		if (errors == 0) $display("tb_chained_hash_key_value_table: clean");
		else $display("tb_chained_hash_key_value_table: errors");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/chkv_pkg.sv
hw/rtl/chkv_ram.sv
hw/rtl/chkv_front.sv
hw/rtl/chkv_fifo.sv
hw/rtl/chkv_back.sv
hw/rtl/chained_hash_key_value_table.sv
test/tb_chained_hash_key_value_table.sv
